// ===== rtl/multiword_by_word_divider_core_macros.svh =====
// Assertion macros shared by the divider RTL.
`ifndef MULTIWORD_BY_WORD_DIVIDER_CORE_MACROS_SVH
`define MULTIWORD_BY_WORD_DIVIDER_CORE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MWDIV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MWDIV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mwdiv_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the multiword-by-word divider.
package mwdiv_pkg;

    // Width of every payload field on the channels.
    localparam int FIELD_BITS    = 64;
    // Default working word width of the divider datapath.
    localparam int WORD_BITS_DEF = 64;
    // Partial products per full word multiply.
    localparam int MAC_PARTS     = 4;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic       en;    // issue one partial product this cycle
        logic       clr;   // clear the accumulator
        logic [1:0] part;  // bit 0 selects the half of a, bit 1 the half of b
    } t_mac_ctl;

endpackage

// ===== rtl/mwdiv_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the multiword-by-word divider.
interface mwdiv_in_if;
    logic                             valid;
    logic                             ready;
    logic [mwdiv_pkg::FIELD_BITS-1:0] dividend_word;
    logic                             last_word;

    modport source (output valid, output dividend_word, output last_word, input ready);
    modport sink (input valid, input dividend_word, input last_word, output ready);
endinterface

interface mwdiv_out_if;
    logic                             valid;
    logic                             ready;
    logic [mwdiv_pkg::FIELD_BITS-1:0] quotient_word;
    logic [mwdiv_pkg::FIELD_BITS-1:0] remainder_word;
    logic                             final_result;

    modport source (output valid, output quotient_word, output remainder_word,
                    output final_result, input ready);
    modport sink (input valid, input quotient_word, input remainder_word,
                  input final_result, output ready);
endinterface

interface mwdiv_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mwdiv_pkg::FIELD_BITS-1:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink (input valid, input divisor, output ready);
endinterface

// ===== rtl/mwdiv_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one half-word product per cycle into a double-word sum.
module mwdiv_mac #(
    parameter int WORD_BITS = mwdiv_pkg::WORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mwdiv_pkg::t_mac_ctl      i_ctl,
    input  logic [WORD_BITS-1:0]     i_a,
    input  logic [WORD_BITS-1:0]     i_b,
    output logic [2*WORD_BITS-1:0]   o_acc
);

    localparam int HB = (WORD_BITS + 1) / 2;
    localparam int AW = 2 * WORD_BITS;

    logic [HB-1:0]   w_a_sel;
    logic [HB-1:0]   w_b_sel;
    logic [2*HB-1:0] w_pp;
    logic [AW-1:0]   w_pp_ext;
    logic [AW-1:0]   w_pp_sh;

    logic [2*HB-1:0] r_pp;
    logic [1:0]      r_sh;
    logic            r_pp_vld;
    logic [AW-1:0]   r_acc;

    always_comb begin
        w_a_sel  = i_ctl.part[0] ? HB'(i_a[WORD_BITS-1:HB]) : i_a[HB-1:0];
        w_b_sel  = i_ctl.part[1] ? HB'(i_b[WORD_BITS-1:HB]) : i_b[HB-1:0];
        w_pp     = w_a_sel * w_b_sel;
        w_pp_ext = AW'(r_pp);
        case (r_sh)
            2'd0:    w_pp_sh = w_pp_ext;
            2'd1:    w_pp_sh = w_pp_ext << HB;
            2'd2:    w_pp_sh = w_pp_ext << (2 * HB);
            default: w_pp_sh = w_pp_ext;
        endcase
    end

    // The product is registered and added into the sum in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_vld <= 1'b0;
        end else begin
            r_pp_vld <= i_ctl.en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp <= w_pp;
        r_sh <= {1'b0, i_ctl.part[0]} + {1'b0, i_ctl.part[1]};
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pp_vld) begin
            r_acc <= r_acc + w_pp_sh;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/multiword_by_word_divider_core.sv =====
`timescale 1ns / 1ps
// Top level of the multiword-by-word divider.
//
// Usage: write the divisor on i_cfg, then stream the dividend on i_in, most
// significant word first, with last_word set on the least significant word.
// Each input word yields one result on o_out holding its quotient word; the
// result for the last word also carries the remainder and final_result.
// A divisor write normalizes the divisor one bit a cycle and then forms its
// reciprocal by restoring division, one bit a cycle; no word is taken
// meanwhile. A divisor of zero is taken as one, and a write clears the
// running remainder.
// A new word is taken only once the previous one has left its last state.
// Each word passes two word multiplies on the shared half-word multiplier,
// the estimate add, the multiply-subtract and two corrections, and the
// output load.
// Reset leaves a divisor of one and a cleared remainder. A result waits in
// the output register while the receiver stalls; the next word is processed
// meanwhile and waits in its last cycle until the register is free.
`include "multiword_by_word_divider_core_macros.svh"

module multiword_by_word_divider_core #(
    parameter int WORD_BITS = mwdiv_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwdiv_in_if.sink    i_in,
    mwdiv_out_if.source o_out,
    mwdiv_cfg_if.sink   i_cfg
);

    localparam int W  = WORD_BITS;
    localparam int SW = $clog2(W);
    localparam int FB = mwdiv_pkg::FIELD_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NORM  = 4'd1;
    localparam logic [3:0] ST_RDIV  = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_EST   = 4'd4;
    localparam logic [3:0] ST_MUL2  = 4'd5;
    localparam logic [3:0] ST_SUB   = 4'd6;
    localparam logic [3:0] ST_CORR1 = 4'd7;
    localparam logic [3:0] ST_CORR2 = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [W-1:0]   TOP_BIT = {1'b1, {(W-1){1'b0}}};
    localparam logic [2*W-1:0] HI_ONE  = {{(W-1){1'b0}}, 1'b1, {W{1'b0}}};
    localparam logic [SW-1:0]  MAC_END = SW'(mwdiv_pkg::MAC_PARTS);
    localparam logic [SW-1:0]  DIV_END = SW'(W - 1);

    // Control and architectural state.
    logic [3:0]    r_state, n_state;
    logic [SW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_d, n_d;        // normalized divisor
    logic [SW-1:0] r_s, n_s;        // normalizing shift
    logic [W-1:0]  r_m, n_m;        // reciprocal
    logic [W-1:0]  r_rem, n_rem;    // running remainder, unshifted
    logic          r_ov, n_ov;

    // Working registers of one step.
    logic [W-1:0]  r_u1, n_u1;
    logic [W-1:0]  r_u0, n_u0;
    logic [W-1:0]  r_q1, n_q1;
    logic [W-1:0]  r_q0, n_q0;
    logic [W-1:0]  r_r, n_r;
    logic          r_last, n_last;
    logic [FB-1:0] r_oq, n_oq;
    logic [FB-1:0] r_orem, n_orem;
    logic          r_ofin, n_ofin;

    logic                 w_in_acc;
    logic                 w_cfg_acc;
    logic                 w_out_free;
    logic [W-1:0]         w_x0;
    logic [W-1:0]         w_cfg_v;
    logic [2*W-1:0]       w_num_sh;
    logic [2*W-1:0]       w_est;
    logic [W-1:0]         w_div_sh;
    logic                 w_div_ge;
    logic [W-1:0]         w_r_out;
    logic [W-1:0]         w_mac_a;
    logic [W-1:0]         w_mac_b;
    logic [2*W-1:0]       w_mac_acc;
    mwdiv_pkg::t_mac_ctl  w_mac_ctl;

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign i_in.ready  = (r_state == ST_IDLE) && !i_cfg.valid;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ov || o_out.ready;

    assign o_out.valid          = r_ov;
    assign o_out.quotient_word  = r_oq;
    assign o_out.remainder_word = r_orem;
    assign o_out.final_result   = r_ofin;

    always_comb begin
        w_x0     = i_in.dividend_word[W-1:0];
        w_cfg_v  = i_cfg.divisor[W-1:0];
        w_num_sh = {r_rem, w_x0} << r_s;
        w_est    = w_mac_acc + {r_u1, r_u0} + HI_ONE;
        // One restoring step of the reciprocal; the low dividend word is all ones.
        w_div_sh = {r_u1[W-2:0], 1'b1};
        w_div_ge = r_u1[W-1] || (w_div_sh >= r_d);
        w_r_out  = r_r >> r_s;

        w_mac_ctl.en   = (r_state inside {ST_MUL1, ST_MUL2}) && (r_cnt != MAC_END);
        w_mac_ctl.clr  = (r_state inside {ST_MUL1, ST_MUL2}) && (r_cnt == '0);
        w_mac_ctl.part = r_cnt[1:0];
        w_mac_a        = (r_state == ST_MUL2) ? r_q1 : r_m;
        w_mac_b        = (r_state == ST_MUL2) ? r_d : r_u1;
    end

    mwdiv_mac #(
        .WORD_BITS (WORD_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_mac_acc)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_s     = r_s;
        n_m     = r_m;
        n_rem   = r_rem;
        n_ov    = r_ov;
        n_u1    = r_u1;
        n_u0    = r_u0;
        n_q1    = r_q1;
        n_q0    = r_q0;
        n_r     = r_r;
        n_last  = r_last;
        n_oq    = r_oq;
        n_orem  = r_orem;
        n_ofin  = r_ofin;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_cfg_acc) begin
                    n_d     = (w_cfg_v == '0) ? W'(1) : w_cfg_v;
                    n_s     = '0;
                    n_rem   = '0;
                    n_state = ST_NORM;
                end else if (w_in_acc) begin
                    n_u1    = w_num_sh[2*W-1:W];
                    n_u0    = w_num_sh[W-1:0];
                    n_last  = i_in.last_word;
                    n_cnt   = '0;
                    n_state = ST_MUL1;
                end
            end
            ST_NORM: begin
                if (r_d[W-1]) begin
                    // Partial remainder and quotient of the reciprocal reuse u1 and q1.
                    n_u1    = ~r_d;
                    n_q1    = '0;
                    n_cnt   = '0;
                    n_state = ST_RDIV;
                end else begin
                    n_d = r_d << 1;
                    n_s = r_s + SW'(1);
                end
            end
            ST_RDIV: begin
                n_u1  = w_div_ge ? (w_div_sh - r_d) : w_div_sh;
                n_q1  = {r_q1[W-2:0], w_div_ge};
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == DIV_END) begin
                    n_m     = n_q1;
                    n_state = ST_IDLE;
                end
            end
            ST_MUL1: begin
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == MAC_END) begin
                    n_state = ST_EST;
                end
            end
            ST_EST: begin
                n_q1    = w_est[2*W-1:W];
                n_q0    = w_est[W-1:0];
                n_cnt   = '0;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_cnt = r_cnt + SW'(1);
                if (r_cnt == MAC_END) begin
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                // Only the low word of q1*d matters.
                n_r     = r_u0 - w_mac_acc[W-1:0];
                n_state = ST_CORR1;
            end
            ST_CORR1: begin
                if (r_r > r_q0) begin
                    n_q1 = r_q1 - W'(1);
                    n_r  = r_r + r_d;
                end
                n_state = ST_CORR2;
            end
            ST_CORR2: begin
                if (r_r >= r_d) begin
                    n_q1 = r_q1 + W'(1);
                    n_r  = r_r - r_d;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_oq    = FB'(r_q1);
                    n_orem  = r_last ? FB'(w_r_out) : '0;
                    n_ofin  = r_last;
                    n_rem   = r_last ? '0 : w_r_out;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_d     <= TOP_BIT;
            r_s     <= SW'(W - 1);
            r_m     <= '1;
            r_rem   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_d     <= n_d;
            r_s     <= n_s;
            r_m     <= n_m;
            r_rem   <= n_rem;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u1   <= n_u1;
        r_u0   <= n_u0;
        r_q1   <= n_q1;
        r_q0   <= n_q0;
        r_r    <= n_r;
        r_last <= n_last;
        r_oq   <= n_oq;
        r_orem <= n_orem;
        r_ofin <= n_ofin;
    end

    // The stored divisor is normalized whenever the block can take work.
    `MWDIV_ASSERT_IMP(a_div_norm, i_clk, i_rst_n,
        r_state == ST_IDLE, r_d[W-1],
        "divisor not normalized")
    // After the first correction at most one more subtraction of d is needed.
    `MWDIV_ASSERT_IMP(a_corr_bound, i_clk, i_rst_n,
        r_state == ST_CORR2, (r_r < r_d) || ((r_r - r_d) < r_d),
        "remainder out of range before last correction")
    // A word in progress keeps the input channel closed.
    `MWDIV_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n,
        w_in_acc, !i_in.ready,
        "input taken while a word is in progress")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the multiword-by-word divider core.
module testbench;

    localparam int FIELD_BITS = mwdiv_pkg::FIELD_BITS;

    typedef logic [FIELD_BITS-1:0] t_word;

    typedef struct {
        t_word quotient;
        t_word remainder;
        logic  is_final;
    } t_div_result;

    // Tracks the divisor and the running remainder, and checks every result
    // against exact long division of the remainder and the incoming word.
    class quotient_tracker;
        t_word       divisor;
        t_word       carry_rem;
        t_div_result expected_words[$];
        int          mismatches;
        int          finals_seen;

        function new();
            divisor     = 1;
            carry_rem   = '0;
            mismatches  = 0;
            finals_seen = 0;
        endfunction

        function void set_divisor(t_word value);
            divisor   = (value == '0) ? t_word'(1) : value;
            carry_rem = '0;
        endfunction

        function void note_word(t_word dividend, logic last);
            logic [2*FIELD_BITS-1:0] partial;
            logic [2*FIELD_BITS-1:0] quot;
            logic [2*FIELD_BITS-1:0] rem;
            t_div_result             res;
            partial = {carry_rem, dividend};
            quot    = partial / {{FIELD_BITS{1'b0}}, divisor};
            rem     = partial % {{FIELD_BITS{1'b0}}, divisor};
            res.quotient  = quot[FIELD_BITS-1:0];
            res.is_final  = last;
            res.remainder = last ? rem[FIELD_BITS-1:0] : '0;
            carry_rem     = last ? '0 : rem[FIELD_BITS-1:0];
            expected_words.push_back(res);
        endfunction

        function void check_word(t_word quotient, t_word remainder, logic is_final);
            t_div_result exp_res;
            if (expected_words.size() == 0) begin
                $error("unexpected result: quotient_word %h with nothing outstanding",
                       quotient);
                mismatches++;
                return;
            end
            exp_res = expected_words.pop_front();
            if (is_final) finals_seen++;
            if (quotient !== exp_res.quotient) begin
                $error("quotient_word mismatch: expected %h, got %h",
                       exp_res.quotient, quotient);
                mismatches++;
            end
            if (remainder !== exp_res.remainder) begin
                $error("remainder_word mismatch: expected %h, got %h",
                       exp_res.remainder, remainder);
                mismatches++;
            end
            if (is_final !== exp_res.is_final) begin
                $error("final_result mismatch: expected %b, got %b",
                       exp_res.is_final, is_final);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mwdiv_in_if  in_if();
    mwdiv_out_if out_if();
    mwdiv_cfg_if cfg_if();

    multiword_by_word_divider_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    quotient_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int divisor_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("multiword_by_word_divider_core test failed");
        $finish;
    end

    // The receiver stalls at random; ready changes only on the falling edge.
    always @(negedge i_clk) begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            tracker.check_word(out_if.quotient_word, out_if.remainder_word,
                               out_if.final_result);
        end
    end

    // Called and returns on a falling edge.
    task automatic send_word(input t_word dividend, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid         = 1'b0;
            in_if.dividend_word = {$urandom, $urandom};
            in_if.last_word     = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        in_if.valid         = 1'b1;
        in_if.dividend_word = dividend;
        in_if.last_word     = last;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_word(dividend, last);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    // Called once all results are drained; waits until the block takes the write.
    task automatic write_divisor(input t_word value);
        cfg_if.valid   = 1'b1;
        cfg_if.divisor = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        tracker.set_divisor(value);
        divisor_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_word pick_divisor();
        t_word value;
        case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = t_word'(1);
            2:       value = '1;
            3:       value = t_word'(1) << $urandom_range(0, FIELD_BITS - 1);
            default: value = {$urandom, $urandom} >> $urandom_range(0, FIELD_BITS - 1);
        endcase
        return value;
    endfunction

    function automatic t_word pick_word(t_word div);
        t_word value;
        case ($urandom_range(0, 11))
            0:       value = '0;
            1:       value = '1;
            2:       value = div - 1;
            3:       value = div;
            4:       value = div + 1;
            5:       value = {$urandom, $urandom} >> $urandom_range(0, FIELD_BITS - 1);
            default: value = {$urandom, $urandom};
        endcase
        return value;
    endfunction

    task automatic run_random(input int count);
        int   target;
        int   len;
        logic broken;
        target = words_sent + count;
        while (words_sent < target) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_drained();
                write_divisor(pick_divisor());
            end
            len    = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(1, 5);
            broken = ($urandom_range(0, 11) == 0);
            for (int k = 0; k < len; k++) begin
                send_word(pick_word(tracker.divisor), !broken && (k == len - 1));
            end
            // An unfinished dividend is abandoned by a divisor write.
            if (broken) begin
                wait_drained();
                write_divisor(pick_divisor());
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.dividend_word = '0;
        in_if.last_word     = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.divisor      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, starting from the reset divisor of one.
        send_word('1, 1'b0);
        send_word('0, 1'b0);
        send_word(t_word'(1), 1'b1);
        wait_drained();
        write_divisor('1);
        send_word('1 - 1, 1'b0);
        send_word('1, 1'b1);
        wait_drained();
        write_divisor('0);
        send_word(t_word'(1) << (FIELD_BITS - 1), 1'b1);
        wait_drained();
        write_divisor(t_word'(1) << (FIELD_BITS - 1));
        send_word('1, 1'b0);
        send_word('1, 1'b0);
        send_word('0, 1'b1);
        wait_drained();
        write_divisor(('1) >> 1);
        send_word('1, 1'b0);
        send_word('1, 1'b1);
        wait_drained();
        write_divisor(t_word'(3));
        send_word('1, 1'b0);
        // A divisor write in the middle of a dividend restarts the division.
        wait_drained();
        write_divisor(t_word'(7));
        send_word(t_word'(5), 1'b1);
        wait_drained();
        write_divisor(t_word'(10));
        send_word({(FIELD_BITS/2){2'b01}}, 1'b0);
        send_word({(FIELD_BITS/2){2'b10}}, 1'b1);
        wait_drained();

        send_idle_pct  = 14;
        recv_stall_pct = 68;
        run_random(210);
        send_idle_pct  = 68;
        recv_stall_pct = 14;
        run_random(210);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(210);

        repeat (40) @(posedge i_clk);
        $display("Divided %0d dividend words into %0d complete dividends",
                 words_sent, tracker.finals_seen);
        $display("over %0d divisor writes, with sender gaps and receiver stalls.",
                 divisor_writes);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("multiword_by_word_divider_core test passed");
        end else begin
            $display("multiword_by_word_divider_core test failed");
        end
        $finish;
    end
endmodule
